@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the RTL. Define NO_ASSERTIONS to
// compile them out.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Clocked check, masked while reset is asserted (active low)
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked check that also holds through reset
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) \
        else $error(msg);

`else

`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg)

`endif

`endif

@@ hw/rtl/pidfd_pkg.sv @@
// ----------------------------------------------------------------------------
// pidfd_pkg
// Types and constants for the PID controller with filtered derivative.
// ----------------------------------------------------------------------------
package pidfd_pkg;

    // Configuration register indexes
    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned CFG_DATA_W = 24;

    localparam logic [CFG_ADDR_W-1:0] REG_P_GAIN    = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_KI_GAIN   = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_D_DECAY   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_D_GAIN    = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_SAT_LIMIT = 3'd4;

    // Reset values of the coefficients
    localparam logic [23:0] P_GAIN_RST    = 24'd1690829;
    localparam logic [23:0] KI_GAIN_RST   = 24'd372429;
    localparam logic [15:0] D_DECAY_RST   = 16'd3524;
    localparam logic [23:0] D_GAIN_RST    = 24'd1818150;
    localparam logic [14:0] SAT_LIMIT_RST = 15'd5734;

    // Coefficient set, Q8.16 gains, Q0.16 pole, Q3.12 clamp
    typedef struct packed {
        logic [23:0] p_gain;
        logic [23:0] ki_gain;
        logic [15:0] d_decay;
        logic [23:0] d_gain;
        logic [14:0] sat_limit;
    } cfg_t;

    // One controller output beat
    typedef struct packed {
        logic signed [15:0] drive;
        logic               clamped;
    } result_t;

endpackage

@@ hw/rtl/pidfd_core.sv @@
// ----------------------------------------------------------------------------
// pidfd_core
// PID arithmetic and loop state. Computes one output from the current
// sample and the stored error, integral and derivative; the state moves on
// when step is high.
// ----------------------------------------------------------------------------
module pidfd_core
    import pidfd_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               step,
    input  logic signed [15:0] reference,
    input  logic signed [15:0] measured,
    input  cfg_t               cfg,
    output result_t            result
);

    // Loop state
    logic signed [16:0] last_error_reg, last_error_next;
    logic signed [31:0] integral_reg,   integral_next;
    logic signed [31:0] deriv_reg,      deriv_next;

    // Error terms (exact)
    logic signed [16:0] err;
    logic signed [17:0] err_diff;

    // Products
    logic signed [41:0] prod_p;
    logic signed [41:0] prod_ki;
    logic signed [48:0] prod_decay;
    logic signed [42:0] prod_dg;

    // Floored terms (product >> 16)
    logic signed [25:0] p_term;
    logic signed [25:0] ki_term;
    logic signed [32:0] decay_term;
    logic signed [26:0] dg_term;

    logic signed [32:0] i_raw;
    logic signed [33:0] d_raw;
    logic signed [33:0] pid_sum;
    logic signed [33:0] lim_pos;
    logic signed [33:0] lim_neg;

    // Error and its change since last sample
    always_comb begin
        err      = {reference[15], reference} - {measured[15], measured};
        err_diff = {err[16], err} - {last_error_reg[16], last_error_reg};
    end

    // Coefficient products, each one multiplier deep
    always_comb begin
        prod_p     = $signed({1'b0, cfg.p_gain})  * err;
        prod_ki    = $signed({1'b0, cfg.ki_gain}) * last_error_reg;
        prod_decay = $signed({1'b0, cfg.d_decay}) * deriv_reg;
        prod_dg    = $signed({1'b0, cfg.d_gain})  * err_diff;
    end

    // Drop 16 fraction bits; taking the upper bits floors
    always_comb begin
        p_term     = prod_p[41:16];
        ki_term    = prod_ki[41:16];
        decay_term = prod_decay[48:16];
        dg_term    = prod_dg[42:16];
    end

    // Integral and filtered derivative, saturated to 32 bits
    always_comb begin
        i_raw = {integral_reg[31], integral_reg} + {{7{ki_term[25]}}, ki_term};
        d_raw = {decay_term[32], decay_term} + {{7{dg_term[26]}}, dg_term};

        if (i_raw[32] != i_raw[31]) begin
            integral_next = i_raw[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
            integral_next = i_raw[31:0];
        end

        if ((d_raw[33:31] == 3'b000) || (d_raw[33:31] == 3'b111)) begin
            deriv_next = d_raw[31:0];
        end else begin
            deriv_next = d_raw[33] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end

        last_error_next = err;
    end

    // Full-width sum and symmetric clamp
    always_comb begin
        pid_sum = {{8{p_term[25]}}, p_term}
                + {{2{integral_next[31]}}, integral_next}
                + {{2{deriv_next[31]}}, deriv_next};
        lim_pos = {19'd0, cfg.sat_limit};
        lim_neg = -lim_pos;

        if (pid_sum > lim_pos) begin
            result.drive   = lim_pos[15:0];
            result.clamped = 1'b1;
        end else if (pid_sum < lim_neg) begin
            result.drive   = lim_neg[15:0];
            result.clamped = 1'b1;
        end else begin
            result.drive   = pid_sum[15:0];
            result.clamped = 1'b0;
        end
    end

    // State update
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_error_reg <= '0;
            integral_reg   <= '0;
            deriv_reg      <= '0;
        end else if (step) begin
            last_error_reg <= last_error_next;
            integral_reg   <= integral_next;
            deriv_reg      <= deriv_next;
        end
    end

endmodule

@@ hw/rtl/pid_filtered_derivative_saturated.sv @@
// ----------------------------------------------------------------------------
// pid_filtered_derivative_saturated
// An accepted beat is held in the input register, then moved to the output
// register once that register is empty or m_ready takes its beat.
// Throughput: one beat per cycle while m_ready is high; the integral and
// derivative feedback close through the core's single multiply-add-saturate path.
// Reset: synchronous, active low; clears both pipeline valid flags and the loop
// state, and loads the coefficient registers with their default values.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pid_filtered_derivative_saturated
    import pidfd_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,

    // Configuration write port
    input  logic                   cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0]  cfg_wr_data,

    // Sample input
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic signed [15:0]     s_reference,
    input  logic signed [15:0]     s_measured,

    // Control output
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic signed [15:0]     m_drive,
    output logic                   m_clamped
);

    cfg_t               cfg_reg;
    logic               in_valid_reg;
    logic signed [15:0] ref_reg;
    logic signed [15:0] meas_reg;
    logic               out_valid_reg;
    result_t            out_reg;
    result_t            core_result;
    logic               advance;

    // Move a beat from the input register to the output register
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // Coefficient registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.p_gain    <= P_GAIN_RST;
            cfg_reg.ki_gain   <= KI_GAIN_RST;
            cfg_reg.d_decay   <= D_DECAY_RST;
            cfg_reg.d_gain    <= D_GAIN_RST;
            cfg_reg.sat_limit <= SAT_LIMIT_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_P_GAIN:    cfg_reg.p_gain    <= cfg_wr_data;
                REG_KI_GAIN:   cfg_reg.ki_gain   <= cfg_wr_data;
                REG_D_DECAY:   cfg_reg.d_decay   <= cfg_wr_data[15:0];
                REG_D_GAIN:    cfg_reg.d_gain    <= cfg_wr_data;
                REG_SAT_LIMIT: cfg_reg.sat_limit <= cfg_wr_data[14:0];
                default: begin
                end
            endcase
        end
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            ref_reg  <= s_reference;
            meas_reg <= s_measured;
        end
    end

    pidfd_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (advance),
        .reference (ref_reg),
        .measured  (meas_reg),
        .cfg       (cfg_reg),
        .result    (core_result)
    );

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= core_result;
        end
    end

    assign m_valid   = out_valid_reg;
    assign m_drive   = out_reg.drive;
    assign m_clamped = out_reg.clamped;

    // Checks
    `ASSERT_CLK_ALWAYS(a_rst_clears_out, aclk, !aresetn |=> !m_valid, "output valid after reset")
    `ASSERT_CLK(a_in_held, aclk, aresetn, in_valid_reg && !advance |=> in_valid_reg, "input beat lost")
    `ASSERT_CLK(a_adv_out, aclk, aresetn, advance |=> m_valid, "advanced beat not presented")
    `ASSERT_CLK(a_clamp_at_lim, aclk, aresetn, m_valid && m_clamped |-> (m_drive == $signed({1'b0, cfg_reg.sat_limit})) || (m_drive == -$signed({1'b0, cfg_reg.sat_limit})), "clamped drive not at limit")
    `ASSERT_CLK(a_in_range, aclk, aresetn, m_valid |-> (m_drive <= $signed({1'b0, cfg_reg.sat_limit})) && (m_drive >= -$signed({1'b0, cfg_reg.sat_limit})), "drive outside limit")

endmodule
